// ----- hw/rtl/gld_pkg.sv -----
package gld_pkg;

	// Widest LZW code that the dictionary supports.
	localparam int unsigned MAX_CODE_BITS = 12;

	// Minimum code size that is in force after reset.
	localparam logic [3:0] MIN_CODE_SIZE_RESET = 4'd8;

	// Request codes carried by req_type.
	localparam logic REQ_PUSH  = 1'b0;
	localparam logic REQ_FETCH = 1'b1;

	// Kind of an item as sorted by the front end.
	typedef enum logic {
		KIND_PUSH,
		KIND_FETCH
	} kind_t;

	// One queued item.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} item_t;

	// Head of the item queue as seen by the back end.
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage

// ----- hw/rtl/gif_lzw_decoder_unit.sv -----
// An item taken from the queue passes through S_ADV (a fetch with pending bytes first through S_POP),
// and each code decoded adds a decode step and a dictionary walk over the bytes of its string;
// a clear or stop code adds only the decode step.
// The back end handles one item at a time and takes the next only after the result handshake.
// The two-entry input queue accepts items while the back end is busy.
// Reset is asynchronous and active low; min_code_size returns to 8 and no memory is cleared.
module gif_lzw_decoder_unit #(
	parameter int unsigned MaxCodeBits = gld_pkg::MAX_CODE_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       req_type,
	input  logic [7:0] stream_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       end_of_string,
	output logic       want_byte,
	output logic       finished,
	output logic [2:0] status
);

	gld_pkg::head_t head;
	logic           pop;

	assign cfg_ready = 1'b1;

	// Input queue.
	gld_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.stream_byte (stream_byte),
		.head        (head),
		.pop         (pop)
	);

	// Decoder engine.
	gld_back #(
		.MaxCodeBits (MaxCodeBits)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.head          (head),
		.pop           (pop),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.out_byte      (out_byte),
		.out_valid     (out_valid),
		.end_of_string (end_of_string),
		.want_byte     (want_byte),
		.finished      (finished),
		.status        (status)
	);

endmodule

// ----- hw/rtl/gld_front.sv -----
module gld_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              req_type,
	input  logic [7:0]        stream_byte,
	output gld_pkg::head_t    head,
	input  logic              pop
);

	gld_pkg::item_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push_en;
	logic           pop_en;
	gld_pkg::item_t in_item;

	// Sort the incoming item by its request code.
	always_comb begin
		in_item.data = stream_byte;
		unique case (req_type)
			gld_pkg::REQ_FETCH: in_item.kind = gld_pkg::KIND_FETCH;
			default:            in_item.kind = gld_pkg::KIND_PUSH;
		endcase
	end

	assign req_stall = (count_q == 2'd2);
	assign push_en   = req_valid && !req_stall;
	assign pop_en    = pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.item  = fifo_q[rd_ptr_q];

	// Two-entry queue storage.
	always_ff @(posedge clk) begin
		if (push_en) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push_en, pop_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/gld_back.sv -----
module gld_back #(
	parameter int unsigned MaxCodeBits = gld_pkg::MAX_CODE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [3:0]        cfg_data,
	input  gld_pkg::head_t    head,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [7:0]        out_byte,
	output logic              out_valid,
	output logic              end_of_string,
	output logic              want_byte,
	output logic              finished,
	output logic [2:0]        status
);

	localparam int unsigned CW    = MaxCodeBits;
	localparam int unsigned DEPTH = 1 << CW;
	localparam int unsigned BW    = CW + 8;
	localparam int unsigned NW    = $clog2(BW + 1);

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_CODE  = 3'd1;
	localparam logic [2:0] ST_EMPTY_SUB = 3'd2;
	localparam logic [2:0] ST_EARLY_END = 3'd3;
	localparam logic [2:0] ST_BAD_TERM  = 3'd4;
	localparam logic [2:0] ST_TURN      = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_ADV,
		S_WALK,
		S_WALK_WR
	} state_t;

	typedef enum logic [1:0] {
		PH_RUN,
		PH_TERM,
		PH_DONE,
		PH_ERR
	} phase_t;

	// Clamp the minimum code size into its legal range.
	function automatic logic [3:0] eff_of(input logic [3:0] sz);
		logic [3:0] r;
		if (sz < 4'd2) begin
			r = 4'd2;
		end else if (sz > 4'd8) begin
			r = 4'd8;
		end else begin
			r = sz;
		end
		return r;
	endfunction

	state_t          state_q;
	phase_t          phase_q;
	logic [2:0]      err_q;
	logic [3:0]      min_size_q;
	logic [3:0]      code_width_q;
	logic [CW:0]     next_free_q;
	logic [CW-1:0]   prev_q;
	logic            prev_none_q;
	logic [7:0]      prev_first_q;
	logic [BW-1:0]   buf_q;
	logic [NW-1:0]   cnt_q;
	logic [7:0]      sub_left_q;
	logic [CW:0]     stk_cnt_q;
	logic [CW-1:0]   c_q;
	logic [CW-1:0]   walk_code_q;
	logic [CW-1:0]   n_q;
	logic            add_pend_q;
	logic [7:0]      hold_byte_q;
	logic            hold_ov_q;
	logic            hold_eos_q;
	logic            hold_turn_q;
	logic            res_valid_q;
	logic [7:0]      res_byte_q;
	logic            res_ov_q;
	logic            res_eos_q;
	logic            res_want_q;
	logic            res_fin_q;
	logic [2:0]      res_status_q;

	// Dictionary holds prefix code and suffix byte per entry.
	logic [CW+7:0]   dict_mem [DEPTH];
	logic [CW+7:0]   dict_rd_q;
	logic [7:0]      stack_mem [DEPTH];
	logic [7:0]      stack_rd_q;

	logic [3:0]      eff;
	logic [CW-1:0]   clr_code;
	logic [CW-1:0]   code;
	logic [BW-1:0]   code_mask;
	logic [NW-1:0]   cnt_after;
	logic            adv_go;
	logic            is_clear;
	logic            is_stop;
	logic            is_bad;
	logic            early_add;
	logic            walk_end;
	logic            dict_we;
	logic [CW+7:0]   dict_wd;
	logic            stk_we;
	logic [CW-1:0]   stk_wa;
	logic [7:0]      stk_wd;
	logic [CW:0]     stk_dec;
	logic [CW:0]     nf_inc;
	logic [3:0]      cw_grown;

	// Code extraction and classification of the next code.
	always_comb begin
		eff        = eff_of(min_size_q);
		clr_code   = CW'(1) << eff;
		code_mask  = (BW'(1) << code_width_q) - BW'(1);
		code       = CW'(buf_q & code_mask);
		cnt_after  = cnt_q - NW'(code_width_q);
		adv_go     = (state_q == S_ADV) && (phase_q == PH_RUN) &&
			(stk_cnt_q == '0) && (cnt_q >= NW'(code_width_q));
		is_clear   = (code == clr_code);
		is_stop    = (code == clr_code + CW'(1));
		if (prev_none_q) begin
			is_bad = (code >= clr_code);
		end else begin
			is_bad = ({1'b0, code} > next_free_q) ||
				(({1'b0, code} == next_free_q) && next_free_q[CW]);
		end
		early_add  = adv_go && !is_clear && !is_stop && !is_bad && !prev_none_q &&
			({1'b0, code} == next_free_q);
		walk_end   = (state_q == S_WALK) && (c_q < clr_code);
		stk_dec    = stk_cnt_q - (CW+1)'(1);
	end

	// Next free slot and the code width that follows an addition.
	always_comb begin
		nf_inc   = next_free_q + (CW+1)'(1);
		cw_grown = code_width_q;
		if ((nf_inc == ((CW+1)'(1) << code_width_q)) && (code_width_q < 4'(CW))) begin
			cw_grown = code_width_q + 4'd1;
		end
	end

	// Memory write controls.
	always_comb begin
		dict_we = early_add || (walk_end && add_pend_q);
		dict_wd = {prev_q, (early_add ? prev_first_q : c_q[7:0])};
		stk_we  = (state_q == S_WALK && walk_end) || (state_q == S_WALK_WR);
		stk_wa  = n_q;
		stk_wd  = (state_q == S_WALK_WR) ? dict_rd_q[7:0] : c_q[7:0];
	end

	// Dictionary memory.
	always_ff @(posedge clk) begin
		if (dict_we) begin
			dict_mem[next_free_q[CW-1:0]] <= dict_wd;
		end
		dict_rd_q <= dict_mem[c_q];
	end

	// String stack memory.
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_wa] <= stk_wd;
		end
		stack_rd_q <= stack_mem[stk_dec[CW-1:0]];
	end

	assign pop = (state_q == S_IDLE) && head.valid && !res_valid_q && !cfg_we;

	// Sequencer for items, code decoding and dictionary walks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_RUN;
			err_q        <= ST_OK;
			min_size_q   <= gld_pkg::MIN_CODE_SIZE_RESET;
			code_width_q <= eff_of(gld_pkg::MIN_CODE_SIZE_RESET) + 4'd1;
			next_free_q  <= ((CW+1)'(1) << eff_of(gld_pkg::MIN_CODE_SIZE_RESET)) +
				(CW+1)'(2);
			prev_q       <= '0;
			prev_none_q  <= 1'b1;
			prev_first_q <= '0;
			buf_q        <= '0;
			cnt_q        <= '0;
			sub_left_q   <= '0;
			stk_cnt_q    <= '0;
			c_q          <= '0;
			walk_code_q  <= '0;
			n_q          <= '0;
			add_pend_q   <= 1'b0;
			hold_byte_q  <= '0;
			hold_ov_q    <= 1'b0;
			hold_eos_q   <= 1'b0;
			hold_turn_q  <= 1'b0;
			res_valid_q  <= 1'b0;
			res_byte_q   <= '0;
			res_ov_q     <= 1'b0;
			res_eos_q    <= 1'b0;
			res_want_q   <= 1'b0;
			res_fin_q    <= 1'b0;
			res_status_q <= ST_OK;
		end else if (cfg_we) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_RUN;
			err_q        <= ST_OK;
			min_size_q   <= cfg_data;
			code_width_q <= eff_of(cfg_data) + 4'd1;
			next_free_q  <= ((CW+1)'(1) << eff_of(cfg_data)) + (CW+1)'(2);
			prev_none_q  <= 1'b1;
			buf_q        <= '0;
			cnt_q        <= '0;
			sub_left_q   <= '0;
			stk_cnt_q    <= '0;
			add_pend_q   <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						hold_byte_q <= '0;
						hold_ov_q   <= 1'b0;
						hold_eos_q  <= 1'b0;
						if (head.item.kind == gld_pkg::KIND_FETCH) begin
							if (stk_cnt_q != '0) begin
								stk_cnt_q   <= stk_dec;
								hold_turn_q <= 1'b0;
								state_q     <= S_POP;
							end else begin
								hold_turn_q <= 1'b1;
								state_q     <= S_ADV;
							end
						end else if (stk_cnt_q != '0 || phase_q == PH_DONE ||
								phase_q == PH_ERR) begin
							hold_turn_q <= 1'b1;
							state_q     <= S_ADV;
						end else begin
							hold_turn_q <= 1'b0;
							state_q     <= S_ADV;
							if (phase_q == PH_TERM) begin
								if (head.item.data == 8'd0) begin
									phase_q <= PH_DONE;
								end else begin
									phase_q <= PH_ERR;
									err_q   <= ST_BAD_TERM;
								end
							end else if (sub_left_q == 8'd0) begin
								if (head.item.data == 8'd0) begin
									phase_q <= PH_ERR;
									err_q   <= ST_EMPTY_SUB;
								end else begin
									sub_left_q <= head.item.data;
								end
							end else begin
								buf_q      <= buf_q | (BW'(head.item.data) << cnt_q);
								cnt_q      <= cnt_q + NW'(8);
								sub_left_q <= sub_left_q - 8'd1;
							end
						end
					end
				end
				S_POP: begin
					hold_byte_q <= stack_rd_q;
					hold_ov_q   <= 1'b1;
					hold_eos_q  <= (stk_cnt_q == '0);
					state_q     <= S_ADV;
				end
				S_ADV: begin
					if (adv_go) begin
						buf_q <= buf_q >> code_width_q;
						cnt_q <= cnt_after;
						if (is_clear) begin
							code_width_q <= eff + 4'd1;
							next_free_q  <= {1'b0, clr_code} + (CW+1)'(2);
							prev_none_q  <= 1'b1;
						end else if (is_stop) begin
							if (sub_left_q == 8'd0 && cnt_after < NW'(8)) begin
								phase_q <= PH_TERM;
							end else begin
								phase_q <= PH_ERR;
								err_q   <= ST_EARLY_END;
							end
						end else if (is_bad) begin
							phase_q <= PH_ERR;
							err_q   <= ST_BAD_CODE;
						end else begin
							walk_code_q <= code;
							c_q         <= code;
							n_q         <= '0;
							add_pend_q  <= !prev_none_q && !next_free_q[CW] &&
								({1'b0, code} != next_free_q);
							if (early_add) begin
								next_free_q  <= nf_inc;
								code_width_q <= cw_grown;
							end
							state_q <= S_WALK;
						end
					end else begin
						// Loop has settled: present the result of this item.
						res_valid_q  <= 1'b1;
						res_byte_q   <= hold_byte_q;
						res_ov_q     <= hold_ov_q;
						res_eos_q    <= hold_eos_q;
						res_want_q   <= (stk_cnt_q == '0) &&
							(phase_q == PH_RUN || phase_q == PH_TERM);
						res_fin_q    <= (phase_q == PH_DONE);
						res_status_q <= (phase_q == PH_ERR) ? err_q :
							(hold_turn_q ? ST_TURN : ST_OK);
						state_q      <= S_IDLE;
					end
				end
				S_WALK: begin
					if (walk_end) begin
						stk_cnt_q    <= {1'b0, n_q} + (CW+1)'(1);
						prev_first_q <= c_q[7:0];
						prev_q       <= walk_code_q;
						prev_none_q  <= 1'b0;
						add_pend_q   <= 1'b0;
						if (add_pend_q) begin
							next_free_q  <= nf_inc;
							code_width_q <= cw_grown;
						end
						state_q <= S_ADV;
					end else begin
						state_q <= S_WALK_WR;
					end
				end
				S_WALK_WR: begin
					n_q     <= n_q + CW'(1);
					c_q     <= dict_rd_q[CW+7:8];
					state_q <= S_WALK;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid     = res_valid_q;
	assign out_byte      = res_byte_q;
	assign out_valid     = res_ov_q;
	assign end_of_string = res_eos_q;
	assign want_byte     = res_want_q;
	assign finished      = res_fin_q;
	assign status        = res_status_q;

endmodule

// ----- tb/gif_lzw_decoder_unit_tb.sv -----
`timescale 1ns / 100ps

module gif_lzw_decoder_unit_tb;

	localparam int unsigned DICT_N = 1 << gld_pkg::MAX_CODE_BITS;

	// Status codes reported by the decoder.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_CODE    = 3'd1;
	localparam logic [2:0] ST_EMPTY_BLOCK = 3'd2;
	localparam logic [2:0] ST_EARLY_STOP  = 3'd3;
	localparam logic [2:0] ST_BAD_TERM    = 3'd4;
	localparam logic [2:0] ST_OUT_OF_TURN = 3'd5;

	typedef enum logic [1:0] {
		PH_RUN,
		PH_TERM,
		PH_DONE,
		PH_FAULT
	} phase_t;

	// Ways in which a generated stream can be broken.
	typedef enum int {
		BRK_NONE,
		BRK_BAD_CODE,
		BRK_FIRST_NOT_LITERAL,
		BRK_EMPTY_BLOCK,
		BRK_EARLY_STOP,
		BRK_BAD_TERM
	} break_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       end_of_string;
		logic       want_byte;
		logic       finished;
		logic [2:0] status;
	} result_t;

	// Decoder predictor together with the queue of results it expects.
	class lzw_scoreboard;
		logic [12:0] prefix_mem [DICT_N];
		logic [7:0]  suffix_mem [DICT_N];
		logic [7:0]  head_mem [DICT_N];
		logic [12:0] len_mem [DICT_N];
		logic [7:0]  stack_mem [DICT_N];
		int unsigned stack_n;
		logic [19:0] bit_buf;
		int unsigned bit_n;
		int unsigned width;
		int unsigned free_code;
		int unsigned prev_code;
		logic        have_prev;
		int unsigned block_left;
		phase_t      phase;
		logic [2:0]  fault_code;
		logic [3:0]  min_size;
		result_t     expected_q[$];
		int unsigned errors;

		function int unsigned eff_size();
			if (min_size < 2)
				return 2;
			if (min_size > 8)
				return 8;
			return min_size;
		endfunction

		function void restart(logic [3:0] size);
			min_size = size;
			stack_n = 0;
			bit_buf = '0;
			bit_n = 0;
			width = eff_size() + 1;
			free_code = (1 << eff_size()) + 2;
			have_prev = 1'b0;
			prev_code = 0;
			block_left = 0;
			phase = PH_RUN;
			fault_code = ST_OK;
		endfunction

		function void stop_with(logic [2:0] code);
			phase = PH_FAULT;
			fault_code = code;
			stack_n = 0;
		endfunction

		// Decode one code: update the dictionary and lay its string on the stack.
		function void decode(int unsigned code);
			int unsigned clr_code;
			int unsigned src;
			int unsigned c;
			clr_code = 1 << eff_size();
			if (code == clr_code) begin
				width = eff_size() + 1;
				free_code = clr_code + 2;
				have_prev = 1'b0;
				return;
			end
			if (code == clr_code + 1) begin
				if (block_left == 0 && bit_n < 8)
					phase = PH_TERM;
				else
					stop_with(ST_EARLY_STOP);
				return;
			end
			if (!have_prev) begin
				if (code >= clr_code) begin
					stop_with(ST_BAD_CODE);
					return;
				end
			end else begin
				if (code > free_code || (code == free_code && free_code >= DICT_N)) begin
					stop_with(ST_BAD_CODE);
					return;
				end
				if (free_code < DICT_N) begin
					src = (code == free_code) ? prev_code : code;
					prefix_mem[free_code] = 13'(prev_code);
					suffix_mem[free_code] = (src < clr_code) ? 8'(src) : head_mem[src];
					head_mem[free_code] = (prev_code < clr_code) ? 8'(prev_code) :
						head_mem[prev_code];
					len_mem[free_code] = (prev_code < clr_code) ? 13'd2 :
						len_mem[prev_code] + 13'd1;
					free_code++;
					if (free_code == (1 << width) && width < gld_pkg::MAX_CODE_BITS)
						width++;
				end
			end
			// The stack holds the string last byte first.
			c = code;
			stack_n = 0;
			while (stack_n < DICT_N) begin
				if (c < clr_code) begin
					stack_mem[stack_n] = 8'(c);
					stack_n++;
					break;
				end
				stack_mem[stack_n] = suffix_mem[c];
				stack_n++;
				c = prefix_mem[c];
			end
			prev_code = code;
			have_prev = 1'b1;
		endfunction

		function void advance();
			int unsigned code;
			while (phase == PH_RUN && stack_n == 0 && bit_n >= width) begin
				code = bit_buf & ((1 << width) - 1);
				bit_buf = bit_buf >> width;
				bit_n -= width;
				decode(code);
			end
		endfunction

		// Note one accepted item and queue the result it must produce.
		function void note_item(logic rtype, logic [7:0] data);
			result_t r;
			r = '0;
			if (rtype == gld_pkg::REQ_FETCH) begin
				if (stack_n > 0) begin
					stack_n--;
					r.out_byte = stack_mem[stack_n];
					r.out_valid = 1'b1;
					r.end_of_string = (stack_n == 0);
					if (stack_n == 0)
						advance();
				end else begin
					r.status = ST_OUT_OF_TURN;
				end
			end else if (stack_n > 0 || phase == PH_DONE || phase == PH_FAULT) begin
				r.status = ST_OUT_OF_TURN;
			end else if (phase == PH_TERM) begin
				if (data == 8'd0)
					phase = PH_DONE;
				else
					stop_with(ST_BAD_TERM);
			end else if (block_left == 0) begin
				if (data == 8'd0)
					stop_with(ST_EMPTY_BLOCK);
				else
					block_left = data;
			end else begin
				bit_buf = bit_buf | (20'(data) << bit_n);
				bit_n += 8;
				block_left--;
				advance();
			end
			if (phase == PH_FAULT)
				r.status = fault_code;
			r.want_byte = (stack_n == 0 && (phase == PH_RUN || phase == PH_TERM));
			r.finished = (phase == PH_DONE);
			expected_q.push_back(r);
		endfunction

		// Compare one accepted result with the oldest expectation.
		function void check_result(result_t got);
			result_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, actual %p", $realtime, got);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.out_byte !== exp_r.out_byte) begin
				$display("%0t: out_byte expected %0h actual %0h", $realtime,
					exp_r.out_byte, got.out_byte);
				errors++;
			end
			if (got.out_valid !== exp_r.out_valid) begin
				$display("%0t: out_valid expected %0b actual %0b", $realtime,
					exp_r.out_valid, got.out_valid);
				errors++;
			end
			if (got.end_of_string !== exp_r.end_of_string) begin
				$display("%0t: end_of_string expected %0b actual %0b", $realtime,
					exp_r.end_of_string, got.end_of_string);
				errors++;
			end
			if (got.want_byte !== exp_r.want_byte) begin
				$display("%0t: want_byte expected %0b actual %0b", $realtime,
					exp_r.want_byte, got.want_byte);
				errors++;
			end
			if (got.finished !== exp_r.finished) begin
				$display("%0t: finished expected %0b actual %0b", $realtime,
					exp_r.finished, got.finished);
				errors++;
			end
			if (got.status !== exp_r.status) begin
				$display("%0t: status expected %0d actual %0d", $realtime,
					exp_r.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [3:0] cfg_data;
	logic       req_valid;
	logic       req_stall;
	logic       req_type;
	logic [7:0] stream_byte;
	logic       res_valid;
	logic       res_stall;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       end_of_string;
	logic       want_byte;
	logic       finished;
	logic [2:0] status;

	lzw_scoreboard sb;
	logic [7:0]    stream_q[$];
	logic          idle_on;
	logic          long_hold;
	int unsigned   items_sent;

	gif_lzw_decoder_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_type     (req_type),
		.stream_byte  (stream_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.out_byte     (out_byte),
		.out_valid    (out_valid),
		.end_of_string(end_of_string),
		.want_byte    (want_byte),
		.finished     (finished),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	// Offer one item after an optional gap and hold it until it is accepted.
	task automatic send_item(logic rtype, logic [7:0] data);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= rtype;
		stream_byte <= data;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_item(rtype, data);
		items_sent++;
	endtask

	// Write min_code_size once the decoder has drained.
	task automatic write_code_size(logic [3:0] value);
		req_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.restart(value);
	endtask

	// Build the bytes of one image data stream from random codes.
	task automatic build_stream(int unsigned n_codes, break_t brk, logic allow_clear);
		bit          bits[$];
		logic [7:0]  payload[$];
		int unsigned clr_code;
		int unsigned gw;
		int unsigned gfree;
		logic        gprev;
		int unsigned code;
		int unsigned r;
		int unsigned blk;
		int unsigned pos;
		int unsigned bad_at;
		int unsigned empty_at;
		logic [7:0]  b;
		clr_code = 1 << sb.eff_size();
		gw = sb.eff_size() + 1;
		gfree = clr_code + 2;
		gprev = 1'b0;
		bad_at = $urandom_range(0, n_codes - 1);
		for (int unsigned i = 0; i <= n_codes; i++) begin
			if (i == n_codes)
				code = clr_code + 1;
			else if (i == 0 && brk == BRK_FIRST_NOT_LITERAL)
				code = $urandom_range(clr_code + 2, 2 * clr_code - 1);
			else if (i == bad_at && brk == BRK_EARLY_STOP)
				code = clr_code + 1;
			else if (i == bad_at && brk == BRK_BAD_CODE && gfree + 1 < (1 << gw))
				code = $urandom_range(gfree + 1, (1 << gw) - 1);
			else if (i == 0 || (allow_clear && $urandom_range(0, 39) == 0))
				code = clr_code;
			else if (!gprev)
				code = $urandom_range(0, clr_code - 1);
			else begin
				r = $urandom_range(0, 9);
				if (r >= 6 && r < 9 && gfree > clr_code + 2)
					code = $urandom_range(clr_code + 2, gfree - 1);
				else if (r == 9 && gfree < DICT_N)
					code = gfree;
				else
					code = $urandom_range(0, clr_code - 1);
			end
			for (int unsigned k = 0; k < gw; k++)
				bits.push_back(code[k]);
			// Follow the decoder's dictionary growth to know the next width.
			if (code == clr_code) begin
				gw = sb.eff_size() + 1;
				gfree = clr_code + 2;
				gprev = 1'b0;
			end else if (code != clr_code + 1) begin
				if (gprev && gfree < DICT_N) begin
					gfree++;
					if (gfree == (1 << gw) && gw < gld_pkg::MAX_CODE_BITS)
						gw++;
				end
				gprev = 1'b1;
			end
		end
		while (bits.size() % 8 != 0)
			bits.push_back($urandom_range(0, 1));
		while (bits.size() > 0) begin
			for (int k = 0; k < 8; k++)
				b[k] = bits.pop_front();
			payload.push_back(b);
		end
		// Split into sub-blocks, mostly short ones.
		stream_q.delete();
		empty_at = $urandom_range(0, 3);
		pos = 0;
		while (payload.size() > 0) begin
			if (brk == BRK_EMPTY_BLOCK && pos == empty_at)
				stream_q.push_back(8'd0);
			blk = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 8);
			if (blk > payload.size())
				blk = payload.size();
			stream_q.push_back(8'(blk));
			repeat (blk)
				stream_q.push_back(payload.pop_front());
			pos++;
		end
		if (brk == BRK_EMPTY_BLOCK && pos <= empty_at)
			stream_q.push_back(8'd0);
		stream_q.push_back((brk == BRK_BAD_TERM) ? 8'($urandom_range(1, 255)) : 8'd0);
	endtask

	// Push a stream, fetching decoded bytes whenever some are pending.
	task automatic run_stream(int unsigned n_codes, break_t brk, logic allow_clear,
			logic noisy);
		int unsigned idx;
		build_stream(n_codes, brk, allow_clear);
		idx = 0;
		while (idx < stream_q.size() || sb.stack_n > 0) begin
			if (noisy && $urandom_range(0, 19) == 0) begin
				// An item out of turn: push while bytes are pending, else fetch.
				if (sb.stack_n > 0)
					send_item(gld_pkg::REQ_PUSH, 8'($urandom_range(0, 255)));
				else
					send_item(gld_pkg::REQ_FETCH, 8'($urandom_range(0, 255)));
			end else if (sb.stack_n > 0) begin
				send_item(gld_pkg::REQ_FETCH, 8'($urandom_range(0, 255)));
			end else begin
				send_item(gld_pkg::REQ_PUSH, stream_q[idx]);
				idx++;
			end
		end
		if (noisy && $urandom_range(0, 3) == 0)
			send_item(gld_pkg::REQ_PUSH, 8'($urandom_range(0, 255)));
	endtask

	// Result side: random stalls, one long hold-off, and the check of every item.
	initial begin
		int unsigned stall_left;
		result_t     got;
		stall_left = 0;
		res_stall <= 1'b1;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				got.out_byte = out_byte;
				got.out_valid = out_valid;
				got.end_of_string = end_of_string;
				got.want_byte = want_byte;
				got.finished = finished;
				got.status = status;
				sb.check_result(got);
				stall_left = idle_on ? $urandom_range(0, 12) : 0;
				if (long_hold) begin
					stall_left = 400;
					long_hold = 1'b0;
				end
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// Stimulus.
	initial begin
		logic pressure_done;
		sb = new();
		sb.restart(gld_pkg::MIN_CODE_SIZE_RESET);
		idle_on = 1'b1;
		long_hold = 1'b0;
		pressure_done = 1'b0;
		items_sent = 0;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		req_valid <= 1'b0;
		req_type <= gld_pkg::REQ_PUSH;
		stream_byte <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset size, range extremes, each kind of broken stream.
		run_stream(3, BRK_NONE, 1'b0, 1'b0);
		send_item(gld_pkg::REQ_FETCH, 8'hff);
		write_code_size(4'd0);
		run_stream(4, BRK_NONE, 1'b0, 1'b0);
		write_code_size(4'd15);
		run_stream(3, BRK_FIRST_NOT_LITERAL, 1'b0, 1'b0);
		write_code_size(4'd1);
		run_stream(4, BRK_BAD_CODE, 1'b0, 1'b0);
		write_code_size(4'd9);
		run_stream(2, BRK_EMPTY_BLOCK, 1'b0, 1'b0);
		write_code_size(4'd3);
		run_stream(3, BRK_EARLY_STOP, 1'b0, 1'b0);
		write_code_size(4'd8);
		run_stream(2, BRK_BAD_TERM, 1'b0, 1'b0);
		send_item(gld_pkg::REQ_PUSH, 8'h00);

		// Random streams with random settings and occasional breakage.
		while (items_sent < 1150) begin
			write_code_size(4'($urandom_range(0, 15)));
			idle_on = ($urandom_range(0, 3) != 0);
			if (!pressure_done && items_sent > 300) begin
				idle_on = 1'b0;
				long_hold = 1'b1;
				pressure_done = 1'b1;
			end
			if ($urandom_range(0, 4) == 0)
				run_stream($urandom_range(1, 40), break_t'($urandom_range(1, 5)), 1'b1,
					1'b1);
			else
				run_stream($urandom_range(1, 60), BRK_NONE, 1'b1, 1'b1);
		end

		// Drain and report.
		req_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
